FILE: hw/rtl/fpa_pkg.sv
// fpa_pkg: types, command and fault codes and the saturating fit helper
// for the Q24.8 fixed-point ALU; used by fpa_div_stage and the top level
// no dependencies
package fpa_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 8;
  localparam int QUO_W  = DATA_W + FRAC_W;
  localparam int PROD_W = 2 * DATA_W;
  localparam int MAG_W  = PROD_W + 1 - FRAC_W;

  localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_GT       = 4'd4,
    CMD_LT       = 4'd5,
    CMD_GE       = 4'd6,
    CMD_LE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_TO_INT   = 4'd12,
    CMD_FROM_INT = 4'd13
  } cmd_t;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_DIV0 = 2'd1;
  localparam logic [1:0] FAULT_OVF  = 2'd2;

  typedef struct packed {
    logic [3:0]               command;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     truth;
    logic [1:0]               fault;
  } out_item_t;

  // everything one item carries down the pipeline
  typedef struct packed {
    logic [3:0]        cmd;
    logic              neg;
    logic              dz;
    out_item_t         simple;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;
    logic [PROD_W-1:0] prod;
    logic [QUO_W-1:0]  num;
    logic [DATA_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
  } pipe_t;

  // apply sign to a magnitude, saturate when it does not fit
  function automatic out_item_t fpa_fit(input logic [MAG_W-1:0] mag, input logic neg);
    logic [MAG_W-1:0] lim;
    out_item_t        res;
    lim = neg ? MAG_W'(MIN_NEG) : MAG_W'(MAX_POS);
    res.truth = 1'b0;
    if (mag > lim) begin
      res.value = neg ? MIN_NEG : MAX_POS;
      res.fault = FAULT_OVF;
    end else begin
      res.value = neg ? -mag[DATA_W-1:0] : mag[DATA_W-1:0];
      res.fault = FAULT_NONE;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/fpa_div_stage.sv
// fpa_div_stage: one registered step of the restoring divider, one
// quotient bit per stage; depends on fpa_pkg
module fpa_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          d_valid,
  input  fpa_pkg::pipe_t d_in,
  output logic          q_valid,
  output fpa_pkg::pipe_t q_out
);

  logic           valid_r;
  fpa_pkg::pipe_t data_r;
  fpa_pkg::pipe_t data_nxt;
  logic [fpa_pkg::DATA_W:0] rem_sh;

  // shift in next dividend bit, subtract divisor when it fits
  always_comb begin
    data_nxt = d_in;
    rem_sh   = {d_in.rem, d_in.num[fpa_pkg::QUO_W-1]};
    data_nxt.num = {d_in.num[fpa_pkg::QUO_W-2:0], 1'b0};
    if (rem_sh >= {1'b0, d_in.mag_b}) begin
      data_nxt.rem = fpa_pkg::DATA_W'(rem_sh - {1'b0, d_in.mag_b});
      data_nxt.quo = {d_in.quo[fpa_pkg::QUO_W-2:0], 1'b1};
    end else begin
      data_nxt.rem = rem_sh[fpa_pkg::DATA_W-1:0];
      data_nxt.quo = {d_in.quo[fpa_pkg::QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign q_valid = valid_r;
  assign q_out   = data_r;

endmodule

FILE: hw/rtl/fixed_point_q24_8_alu_core.sv
// fixed_point_q24_8_alu_core: pipelined Q24.8 fixed-point ALU
// every command takes the same path: input register, stage 1, stage 2, divider stages, output register
// throughput: one item per cycle while the output is not stalled; the 40-stage divider pipeline sets depth
// a stalled output freezes the whole pipeline, nothing is dropped
// reset: synchronous active-low rst_n clears all valid bits
// depends on fpa_pkg and fpa_div_stage
module fixed_point_q24_8_alu_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fpa_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output fpa_pkg::out_item_t  out_item
);

  localparam int DW = fpa_pkg::DATA_W;
  localparam int NQ = fpa_pkg::QUO_W;

  logic adv;

  logic               s0_valid_r;
  fpa_pkg::in_item_t  s0_item_r;
  logic               s1_valid_r;
  fpa_pkg::pipe_t     s1_r;
  fpa_pkg::pipe_t     s1_nxt;
  logic               s2_valid_r;
  fpa_pkg::pipe_t     s2_r;
  fpa_pkg::pipe_t     s2_nxt;

  logic               dv [NQ+1];
  fpa_pkg::pipe_t     dd [NQ+1];

  logic               out_valid_r;
  fpa_pkg::out_item_t out_item_r;
  fpa_pkg::out_item_t out_nxt;

  // whole pipeline moves unless a finished item waits
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_item_r <= in_item;
    end
  end

  // stage 1: simple commands, magnitudes and divider setup
  always_comb begin
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic [DW-1:0] sum;
    logic          lt;
    logic          gt;
    logic          eq;
    a   = s0_item_r.operand_a;
    b   = s0_item_r.operand_b;
    lt  = $signed(a) < $signed(b);
    gt  = $signed(a) > $signed(b);
    eq  = a == b;
    sum = '0;
    s1_nxt = '0;
    s1_nxt.cmd   = s0_item_r.command;
    s1_nxt.neg   = a[DW-1] ^ b[DW-1];
    s1_nxt.dz    = b == '0;
    s1_nxt.mag_a = a[DW-1] ? -a : a;
    s1_nxt.mag_b = b[DW-1] ? -b : b;
    s1_nxt.num   = {s1_nxt.mag_a, {fpa_pkg::FRAC_W{1'b0}}};
    s1_nxt.simple.value = '0;
    s1_nxt.simple.truth = 1'b0;
    s1_nxt.simple.fault = fpa_pkg::FAULT_NONE;
    unique case (s0_item_r.command)
      fpa_pkg::CMD_ADD: begin
        sum = a + b;
        if (a[DW-1] == b[DW-1] && sum[DW-1] != a[DW-1]) begin
          s1_nxt.simple.value = a[DW-1] ? fpa_pkg::MIN_NEG : fpa_pkg::MAX_POS;
          s1_nxt.simple.fault = fpa_pkg::FAULT_OVF;
        end else begin
          s1_nxt.simple.value = sum;
        end
      end
      fpa_pkg::CMD_SUB: begin
        sum = a - b;
        if (a[DW-1] != b[DW-1] && sum[DW-1] != a[DW-1]) begin
          s1_nxt.simple.value = a[DW-1] ? fpa_pkg::MIN_NEG : fpa_pkg::MAX_POS;
          s1_nxt.simple.fault = fpa_pkg::FAULT_OVF;
        end else begin
          s1_nxt.simple.value = sum;
        end
      end
      fpa_pkg::CMD_DIV: begin
        if (b == '0) begin
          s1_nxt.simple.value = a[DW-1] ? fpa_pkg::MIN_NEG : fpa_pkg::MAX_POS;
          s1_nxt.simple.fault = fpa_pkg::FAULT_DIV0;
        end
      end
      fpa_pkg::CMD_GT:  s1_nxt.simple.truth = gt;
      fpa_pkg::CMD_LT:  s1_nxt.simple.truth = lt;
      fpa_pkg::CMD_GE:  s1_nxt.simple.truth = !lt;
      fpa_pkg::CMD_LE:  s1_nxt.simple.truth = !gt;
      fpa_pkg::CMD_EQ:  s1_nxt.simple.truth = eq;
      fpa_pkg::CMD_NE:  s1_nxt.simple.truth = !eq;
      fpa_pkg::CMD_MIN: s1_nxt.simple.value = lt ? a : b;
      fpa_pkg::CMD_MAX: s1_nxt.simple.value = gt ? a : b;
      fpa_pkg::CMD_TO_INT: begin
        s1_nxt.simple.value = $signed(a) >>> fpa_pkg::FRAC_W;
      end
      fpa_pkg::CMD_FROM_INT: begin
        // fits when the bits shifted out and the new sign bit all equal the sign
        if (a[DW-1:DW-1-fpa_pkg::FRAC_W] != '0 &&
            a[DW-1:DW-1-fpa_pkg::FRAC_W] != '1) begin
          s1_nxt.simple.value = a[DW-1] ? fpa_pkg::MIN_NEG : fpa_pkg::MAX_POS;
          s1_nxt.simple.fault = fpa_pkg::FAULT_OVF;
        end else begin
          s1_nxt.simple.value = a << fpa_pkg::FRAC_W;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= s0_valid_r;
      s2_valid_r <= s1_valid_r;
    end
  end

  // stage 2: magnitude product
  always_comb begin
    s2_nxt      = s1_r;
    s2_nxt.prod = s1_r.mag_a * s1_r.mag_b;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  // divider pipeline, one quotient bit per stage
  assign dv[0] = s2_valid_r;
  assign dd[0] = s2_r;

  for (genvar i = 0; i < NQ; i++) begin : g_div
    fpa_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .d_valid (dv[i]),
      .d_in    (dd[i]),
      .q_valid (dv[i+1]),
      .q_out   (dd[i+1])
    );
  end

  // final stage: round and saturate product or quotient, pick result
  always_comb begin
    logic [fpa_pkg::PROD_W:0]  msum;
    logic [NQ:0]               dq;
    logic                      up;
    fpa_pkg::pipe_t            p;
    p    = dd[NQ];
    msum = {1'b0, p.prod} + (fpa_pkg::PROD_W+1)'(1 << (fpa_pkg::FRAC_W - 1));
    up   = {p.rem, 1'b0} >= {1'b0, p.mag_b};
    dq   = {1'b0, p.quo} + (NQ+1)'(up);
    out_nxt = p.simple;
    if (p.cmd == fpa_pkg::CMD_MUL) begin
      out_nxt = fpa_pkg::fpa_fit(msum[fpa_pkg::PROD_W:fpa_pkg::FRAC_W], p.neg);
    end else if (p.cmd == fpa_pkg::CMD_DIV && !p.dz) begin
      out_nxt = fpa_pkg::fpa_fit(fpa_pkg::MAG_W'(dq), p.neg);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv[NQ];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks on result consistency
  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_item_r.fault != 2'd3)
    else $error("undefined fault code");

  a_truth_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.truth |-> out_item_r.value == '0 &&
    out_item_r.fault == fpa_pkg::FAULT_NONE)
    else $error("comparison result carries a value");

  a_fault_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.fault != fpa_pkg::FAULT_NONE |->
    out_item_r.value == fpa_pkg::MAX_POS || out_item_r.value == fpa_pkg::MIN_NEG)
    else $error("fault without saturated value");

  a_div0_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.fault == fpa_pkg::FAULT_DIV0 |-> !out_item_r.truth)
    else $error("division fault on comparison");

endmodule
